// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker file smpq_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/smpq_pkg.sv =====
`default_nettype none
package smpq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CAP_W    = 5;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);
  localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(16);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t entry;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/sorted_min_priority_queue_unit.sv =====
// a result beat appears in the cycle after its input beat is accepted
// throughput: one enqueue or dequeue per cycle while not stalled; every cell
//   compares its key with the new key in parallel, so no operation iterates
// reset (rst, synchronous): queue empty, capacity_limit = 16, no result pending
// stored keys and tags are not cleared; only slots below the count are read
`default_nettype none
module sorted_min_priority_queue_unit (
  input  logic                         clk,
  input  logic                         rst,
  // operation channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [smpq_pkg::KEY_W-1:0]   key_in,
  input  logic [smpq_pkg::TAG_W-1:0]   tag_in,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [smpq_pkg::KEY_W-1:0]   key_out,
  output logic [smpq_pkg::TAG_W-1:0]   tag_out,
  output logic [smpq_pkg::COUNT_W-1:0] count,
  output logic                         is_empty,
  output logic                         is_full,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smpq_pkg::ADDR_W-1:0]  paddr,
  input  logic [smpq_pkg::DATA_W-1:0]  pwdata,
  output logic [smpq_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import smpq_pkg::*;

  // configuration
  logic [CAP_W-1:0] capacity_limit;
  logic             cfg_write;

  // occupancy and control
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic             accept;
  logic             is_deq;
  logic             full_now;
  logic             empty_now;
  logic             enq_ok;
  logic             deq_ok;
  logic [31:0]      eff_cap;
  cell_cmd_t        cmd;

  // cell row
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] shift;
  entry_t           cell_entry [DEPTH];

  // apb: zero wait states, only the capacity register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ADDR_CAPACITY) ? DATA_W'(capacity_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_write && (paddr == ADDR_CAPACITY)) begin
      capacity_limit <= pwdata[CAP_W-1:0];
    end
  end

  // a new beat enters whenever the result register is free or being drained
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_deq   = (op_t'(op) == OP_DEQ);

  // capacity above the row size clamps to the row size
  assign eff_cap   = (32'(capacity_limit) > DEPTH) ? DEPTH : 32'(capacity_limit);
  assign full_now  = 32'(entry_count) >= eff_cap;
  assign empty_now = (entry_count == '0);
  assign enq_ok    = accept && !is_deq && !full_now;
  assign deq_ok    = accept && is_deq && !empty_now;

  always_comb begin
    entry_count_next = entry_count;
    if (enq_ok) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (deq_ok) begin
      entry_count_next = entry_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  // command broadcast along the row
  assign cmd.enq       = enq_ok;
  assign cmd.deq       = deq_ok;
  assign cmd.entry.key = key_in;
  assign cmd.entry.tag = TAG_BITS'(tag_in);

  // cell i holds a live entry when i is below the count
  // keys ascend from cell 0; an enqueue shifts the tail right by one,
  // a dequeue shifts every cell left by one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_occ;
    logic   left_shift;
    entry_t left_entry;
    entry_t right_entry;

    assign occ[i] = (CNT_W'(i) < entry_count);

    if (i == 0) begin : g_head
      assign left_occ   = 1'b1;
      assign left_shift = 1'b0;
      assign left_entry = cmd.entry;
    end else begin : g_body
      assign left_occ   = occ[i-1];
      assign left_shift = shift[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (occ[i]),
      .left_occ    (left_occ),
      .left_shift  (left_shift),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .shift       (shift[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok       <= enq_ok || deq_ok;
      // front cell holds the smallest key
      key_out  <= deq_ok ? cell_entry[0].key : '0;
      tag_out  <= deq_ok ? TAG_W'(cell_entry[0].tag) : '0;
      count    <= COUNT_W'(entry_count_next);
      is_empty <= (entry_count_next == '0);
      is_full  <= 32'(entry_count_next) >= eff_cap;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smpq_cell.sv =====
`default_nettype none
module smpq_cell (
  input  logic               clk,
  input  smpq_pkg::cell_cmd_t cmd,
  input  logic               occ,
  input  logic               left_occ,
  input  logic               left_shift,
  input  smpq_pkg::entry_t   left_entry,
  input  smpq_pkg::entry_t   right_entry,
  output smpq_pkg::entry_t   entry,
  output logic               shift
);
  import smpq_pkg::*;

  logic take;

  // strictly greater: equal keys stay ahead of the new one
  assign shift = occ && (entry.key > cmd.entry.key);
  // first free slot also takes data: the shifted entry, or the new one when nothing ahead moved
  assign take  = shift || (!occ && left_occ);

  always_ff @(posedge clk) begin
    if (cmd.enq && take) begin
      entry <= left_shift ? left_entry : cmd.entry;
    end else if (cmd.deq) begin
      entry <= right_entry;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smpq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module smpq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         ok,
  input logic [smpq_pkg::KEY_W-1:0]   key_out,
  input logic [smpq_pkg::TAG_W-1:0]   tag_out,
  input logic [smpq_pkg::COUNT_W-1:0] count,
  input logic                         is_empty
);
  import smpq_pkg::*;

  // an accepted beat always shows up on the next cycle
  `ASSERT_NXT(a_result_follows, clk, rst, in_valid && !in_stall, out_valid)
  // empty flag tracks the reported count
  `ASSERT_IMP(a_empty_flag, clk, rst, out_valid, is_empty == (count == '0))
  // failures return no entry
  `ASSERT_IMP(a_no_data_on_fail, clk, rst, out_valid && !ok, key_out == '0 && tag_out == '0)
  // count never exceeds the row size
  `ASSERT_IMP(a_count_bound, clk, rst, out_valid, 32'(count) <= DEPTH)
  // a stalled result beat stays put
  `ASSERT_NXT(a_stall_hold, clk, rst, out_valid && out_stall, out_valid && $stable(key_out) && $stable(tag_out) && $stable(count))

endmodule

bind sorted_min_priority_queue_unit smpq_checker u_smpq_checker (.*);
`default_nettype wire

// ===== test/smpq_order_checker.sv =====
module smpq_order_checker
  import smpq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               op,
  input  logic [KEY_W-1:0]   key_in,
  input  logic [TAG_W-1:0]   tag_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               ok,
  input  logic [KEY_W-1:0]   key_out,
  input  logic [TAG_W-1:0]   tag_out,
  input  logic [COUNT_W-1:0] count,
  input  logic               is_empty,
  input  logic               is_full,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output int                 fail_count
);

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } queue_result_t;

  entry_t           sorted_entries [DEPTH];
  int unsigned      held;
  logic [CAP_W-1:0] cap_limit;
  queue_result_t    awaited_results [$];
  int               mismatches = 0;
  int               pending = 0;

  // results still owed at the end count as failures too
  assign fail_count = mismatches + pending;

  function automatic bit at_capacity();
    int unsigned limit;
    limit = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    return held >= limit;
  endfunction

  task automatic predict_queue_op(input op_t kind, input logic [KEY_W-1:0] new_key,
                                  input logic [TAG_W-1:0] new_tag,
                                  output queue_result_t res);
    int unsigned pos;
    res = '0;
    if (kind == OP_ENQ) begin
      if (!at_capacity()) begin
        // equal keys keep arrival order: insert after every key <= new one
        pos = 0;
        while (pos < held && sorted_entries[pos].key <= new_key) pos++;
        for (int i = held; i > pos; i--) sorted_entries[i] = sorted_entries[i-1];
        sorted_entries[pos].key = new_key;
        sorted_entries[pos].tag = new_tag[TAG_BITS-1:0];
        held++;
        res.ok = 1'b1;
      end
    end else if (held != 0) begin
      res.ok  = 1'b1;
      res.key = sorted_entries[0].key;
      res.tag = TAG_W'(sorted_entries[0].tag);
      for (int i = 0; i + 1 < held; i++) sorted_entries[i] = sorted_entries[i+1];
      held--;
    end
    res.count = COUNT_W'(held);
    res.empty = (held == 0);
    res.full  = at_capacity();
  endtask

  function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    int bad;
    if (rst) begin
      held = 0;
      cap_limit = CAP_RESET;
      awaited_results.delete();
    end else begin
      // a result beat never belongs to the op beat taken at the same edge
      if (out_valid && !out_stall) begin
        got = '{ok, key_out, tag_out, count, is_empty, is_full};
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual %p", $time, got);
        end else begin
          want = awaited_results.pop_front();
          bad = field_differs("ok", want.ok, got.ok)
              + field_differs("key_out", want.key, got.key)
              + field_differs("tag_out", want.tag, got.tag)
              + field_differs("count", want.count, got.count)
              + field_differs("is_empty", want.empty, got.empty)
              + field_differs("is_full", want.full, got.full);
          if (bad != 0) mismatches++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_queue_op(op_t'(op), key_in, tag_in, want);
        awaited_results.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY)
        cap_limit = pwdata[CAP_W-1:0];
    end
    pending = awaited_results.size();
  end

endmodule

// ===== test/tb_sorted_min_priority_queue_unit.sv =====
module tb_sorted_min_priority_queue_unit;
  import smpq_pkg::*;

  // clock, reset and every block input start at known values
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = OP_ENQ;
  logic [KEY_W-1:0]   key_in = '0;
  logic [TAG_W-1:0]   tag_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic [KEY_W-1:0]   key_out;
  logic [TAG_W-1:0]   tag_out;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic               is_full;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int fail_count;
  int ops_sent = 0;      // op beats accepted
  int results_seen = 0;  // result beats accepted
  bit calm = 1'b0;       // no idling on either side while set
  bit hold_req = 1'b0;   // asks the result side for one long hold-off

  always #1 clk = ~clk;

  sorted_min_priority_queue_unit DUT (.*);

  smpq_order_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .op, .key_in, .tag_in,
    .out_valid, .out_stall, .ok, .key_out, .tag_out, .count, .is_empty, .is_full,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count
  );

  // result beats taken, used to find when the block has gone idle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  // result side: random stalls about a quarter of the time, none while calm;
  // on request one long hold-off, counted here, so the queue backs up and
  // the op channel stalls while the sender keeps offering beats
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < 80; c++) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  // one op beat; an optional gap of idle cycles first, then hold the beat
  // steady until the block takes it
  task automatic push_op(input op_t kind, input logic [KEY_W-1:0] k,
                         input logic [TAG_W-1:0] t);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    key_in   <= k;
    tag_in   <= t;
    do @(posedge clk); while (in_stall);
    ops_sent++;
  endtask

  // drop valid and wait until every op has answered, plus a short drain
  task automatic settle();
    in_valid <= 1'b0;
    while (results_seen != ops_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_capacity(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // keys: extremes, a few small integer distances so ties are common,
  // otherwise any Q16.16 value
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 7)) << 16;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  int unsigned phase_cap [8] = '{16, 31, 3, 0, 17, 1, 9, 16};
  int unsigned enq_pct   [8] = '{75, 65, 50, 40, 80, 30, 55, 35};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity: dequeue from empty, key and tag extremes, ties
    // that must leave in arrival order, then drain past empty
    push_op(OP_DEQ, '0, '0);
    push_op(OP_ENQ, '0, '0);
    push_op(OP_ENQ, '1, '1);
    push_op(OP_ENQ, 32'h0001_0000, 16'd1);
    push_op(OP_ENQ, 32'h0001_0000, 16'd2);
    push_op(OP_ENQ, 32'h0001_0000, 16'd3);
    push_op(OP_ENQ, '0, '1);
    repeat (7) push_op(OP_DEQ, '1, '1);
    settle();

    // capacity of zero: every enqueue fails, queue reports full
    write_capacity(0);
    push_op(OP_ENQ, 32'h1234_5678, 16'h00ff);
    push_op(OP_DEQ, '0, '0);
    settle();

    // capacity of one: second enqueue fails, entry kept
    write_capacity(1);
    push_op(OP_ENQ, 32'h0005_0000, 16'd5);
    push_op(OP_ENQ, 32'h0006_0000, 16'd6);
    settle();

    // capacity above the depth
    write_capacity(31);
    push_op(OP_ENQ, 32'h8000_0000, 16'h8000);
    push_op(OP_ENQ, 32'h0000_0001, 16'h0001);
    push_op(OP_ENQ, 32'h7fff_ffff, 16'h7fff);
    settle();

    // capacity lowered below the count: enqueue fails until the count drops below it
    write_capacity(2);
    push_op(OP_ENQ, 32'h0002_0000, 16'd2);
    repeat (3) push_op(OP_DEQ, '0, '0);
    push_op(OP_ENQ, 32'h0003_0000, 16'd3);
    settle();

    // random phases; entries carry over so capacity changes also land
    // on a partly filled queue
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(ph == 6 ? $urandom_range(0, 31) : phase_cap[ph]);
      if (ph == 1) hold_req = 1'b1;
      calm = (ph == 4);
      for (int n = 0; n < 228; n++) begin
        if ($urandom_range(99) < enq_pct[ph])
          push_op(OP_ENQ, pick_key(), TAG_W'($urandom));
        else
          push_op(OP_DEQ, KEY_W'($urandom), TAG_W'($urandom));
      end
      settle();
    end
    calm = 1'b0;

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sorted_min_priority_queue_unit.f =====
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_cell.sv
hdl/sorted_min_priority_queue_unit.sv
hdl/smpq_checker.sv
test/smpq_order_checker.sv
test/tb_sorted_min_priority_queue_unit.sv
